### hdl/ssfl_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and widths for the slab slot free-list allocator
// no dependencies; every other file imports this package

package ssfl_pkg;

  localparam int unsigned PAGE_BYTES   = 65536;
  localparam int unsigned HEADER_BYTES = 64;
  localparam int unsigned MAX_SLOTS    = 8192;
  localparam int unsigned LINK_BYTES   = 8;

  localparam int unsigned SLOT_W = $clog2(MAX_SLOTS);      // slot index
  localparam int unsigned CNT_W  = $clog2(MAX_SLOTS + 1);  // counts and links
  localparam int unsigned BYTE_W = 16;                     // slot size, byte offset
  localparam int unsigned OFF_W  = 17;                     // data offset
  localparam int unsigned DIV_W  = $clog2(PAGE_BYTES + 1); // capacity dividend
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // link value meaning end of the free list
  localparam logic [CNT_W-1:0] NO_SLOT = CNT_W'(MAX_SLOTS);

  localparam logic [BYTE_W-1:0] OBJ_BYTES_RST = BYTE_W'(8);

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_SLOT     = 2'd1,
    ST_NOT_IN_USE  = 2'd2
  } status_t;

  // register index taken from address bit 2
  localparam logic REG_OBJECT_BYTES = 1'b0;

endpackage

### hdl/ssfl_ifs.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the command input and the result output
// depends on ssfl_pkg for field widths

interface ssfl_in_if import ssfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SLOT_W-1:0] slot_in;

  modport source (output valid, command, slot_in, input ready);
  modport sink   (input valid, command, slot_in, output ready);
endinterface

interface ssfl_out_if import ssfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [SLOT_W-1:0] slot_out;
  logic [BYTE_W-1:0] slot_byte_offset;
  logic              page_now_unused;
  logic              is_full;
  logic              is_empty;
  logic [CNT_W-1:0]  used_slots;
  logic [CNT_W-1:0]  capacity_out;

  modport source (output valid, status, slot_out, slot_byte_offset, page_now_unused,
                  is_full, is_empty, used_slots, capacity_out, input ready);
  modport sink   (input valid, status, slot_out, slot_byte_offset, page_now_unused,
                  is_full, is_empty, used_slots, capacity_out, output ready);
endinterface

### hdl/ssfl_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, used for the page capacity
// depends on ssfl_pkg for widths

module ssfl_div import ssfl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [BYTE_W-1:0] divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quotient
);

  localparam int unsigned STEP_W = $clog2(DIV_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [BYTE_W:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [BYTE_W-1:0] dvs_r, dvs_nxt;
  logic [BYTE_W:0]   trial;
  logic              fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_r[BYTE_W-1:0], quo_r[DIV_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? (trial - {1'b0, dvs_r}) : trial;
      quo_nxt  = {quo_r[DIV_W-2:0], fits};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### hdl/slab_slot_free_list_allocator.sv
`timescale 1ns / 1ps
// slab slot free-list allocator: one page of fixed-size slots, link memory and control
// depends on ssfl_pkg, ssfl_ifs (channel interfaces) and ssfl_div
//
// usage: commands enter on in_ch (init page, allocate slot, free slot), one result
// per command leaves on out_ch; both are valid/ready, a transfer happens when both
// are high. the slot size sits in the object_bytes register (apb address 0) and is
// taken by the next init. one command is worked on at a time.
// alloc and free: for alloc the transfer cycle reads the link memory at the free-list
// head; the exec state, once the output register is free, writes back head (and the
// link on free) and loads the result. init with a valid slot size runs the bit-serial
// capacity divider, then writes the slot-order links into the link memory, one per slot.
// the result sits in an output register, so a new command is taken while it waits;
// if the receiver stalls, the following command finishes its work and then holds
// in its last cycle until the output register frees up.
// reset (synchronous, rst_n low) gives an empty page with capacity zero and
// object_bytes = 8; the link memory is left as is and its contents are used only where written.

module slab_slot_free_list_allocator import ssfl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  ssfl_in_if.sink           in_ch,
  ssfl_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FILL,
    S_EXEC
  } state_t;

  state_t            state_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  head_r;
  logic [CNT_W-1:0]  used_r;
  logic [CNT_W-1:0]  cap_r;
  logic [OFF_W-1:0]  off_r;
  logic [BYTE_W-1:0] size_r;
  logic [BYTE_W-1:0] obj_r;
  logic [CNT_W-1:0]  fill_r;
  logic [BYTE_W-1:0] prod_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [BYTE_W-1:0] out_boff_r;
  logic              out_unused_r;
  logic              out_full_r;
  logic              out_empty_r;
  logic [CNT_W-1:0]  out_used_r;
  logic [CNT_W-1:0]  out_cap_r;

  // link memory
  logic [CNT_W-1:0]  link_mem [MAX_SLOTS];
  logic [CNT_W-1:0]  rd_data_r;
  logic              rd_en;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [CNT_W-1:0]  wr_data;

  logic              accept;
  logic              out_free;
  logic              cfg_wr;
  logic [OFF_W-1:0]  init_off;
  logic              init_ok;
  logic [DIV_W-1:0]  div_dividend;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;
  logic [CNT_W-1:0]  div_cap;
  logic [CNT_W-1:0]  fill_inc;

  // result of the exec cycle
  logic              alloc_ok;
  logic              free_do;
  logic [STAT_W-1:0] res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [BYTE_W-1:0] res_boff;
  logic              res_unused;
  logic [CNT_W-1:0]  used_nxt;
  logic [CNT_W-1:0]  head_nxt;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_OBJECT_BYTES) ? DATA_W'(obj_r) : '0;

  // data offset is the larger of slot size and header
  assign init_off = (obj_r > BYTE_W'(HEADER_BYTES)) ? OFF_W'(obj_r) : OFF_W'(HEADER_BYTES);
  assign init_ok  = (obj_r >= BYTE_W'(LINK_BYTES)) && (init_off < OFF_W'(PAGE_BYTES));
  assign div_dividend = DIV_W'(PAGE_BYTES) - DIV_W'(init_off);

  ssfl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && (in_ch.command == CMD_INIT) && init_ok),
    .dividend (div_dividend),
    .divisor  (obj_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign div_cap  = (div_quo > DIV_W'(MAX_SLOTS)) ? NO_SLOT : div_quo[CNT_W-1:0];
  assign fill_inc = fill_r + CNT_W'(1);

  always_comb begin
    alloc_ok   = (head_r < NO_SLOT) && (head_r < cap_r);
    free_do    = 1'b0;
    res_status = ST_OK;
    res_slot   = '0;
    res_boff   = '0;
    res_unused = 1'b0;
    used_nxt   = used_r;
    head_nxt   = head_r;
    unique case (cmd_r)
      CMD_INIT: begin
        used_nxt = '0;
      end
      CMD_ALLOC: begin
        if (alloc_ok) begin
          head_nxt = rd_data_r;
          used_nxt = used_r + CNT_W'(1);
          res_slot = head_r[SLOT_W-1:0];
          res_boff = off_r[BYTE_W-1:0] + prod_r;
        end else begin
          res_status = ST_NO_SLOT;
        end
      end
      CMD_FREE: begin
        if (used_r == '0) begin
          res_status = ST_NOT_IN_USE;
        end else if (CNT_W'(slot_r) < cap_r) begin
          free_do    = 1'b1;
          head_nxt   = CNT_W'(slot_r);
          res_unused = (used_r == CNT_W'(1));
          used_nxt   = used_r - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // single write port: slot-order links during fill, pushed slot on free
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_r[SLOT_W-1:0];
    wr_data = (fill_inc == cap_r) ? NO_SLOT : fill_inc;
    if (state_r == S_FILL) begin
      wr_en = 1'b1;
    end else if (state_r == S_EXEC && out_free && free_do) begin
      wr_en   = 1'b1;
      wr_addr = slot_r;
      wr_data = head_r;
    end
  end

  assign rd_en = accept && (in_ch.command == CMD_ALLOC);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= link_mem[head_r[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NO_SLOT;
      used_r      <= '0;
      cap_r       <= '0;
      off_r       <= '0;
      size_r      <= '0;
      obj_r       <= OBJ_BYTES_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == REG_OBJECT_BYTES) begin
        obj_r <= pwdata[BYTE_W-1:0];
      end
      // the exec cycle reloads the output register itself
      if (out_valid_r && out_ch.ready && state_r != S_EXEC) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r  <= in_ch.command;
            slot_r <= in_ch.slot_in;
            // low bits of the slot offset product, added to the data offset later
            prod_r <= BYTE_W'(head_r[SLOT_W-1:0] * size_r);
            if (in_ch.command == CMD_INIT) begin
              size_r <= obj_r;
              off_r  <= init_off;
              used_r <= '0;
              if (init_ok) begin
                state_r <= S_DIV;
              end else begin
                cap_r   <= '0;
                head_r  <= NO_SLOT;
                state_r <= S_EXEC;
              end
            end else begin
              state_r <= S_EXEC;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            cap_r  <= div_cap;
            fill_r <= '0;
            if (div_cap == '0) begin
              head_r  <= NO_SLOT;
              state_r <= S_EXEC;
            end else begin
              head_r  <= '0;
              state_r <= S_FILL;
            end
          end
        end
        S_FILL: begin
          fill_r <= fill_inc;
          if (fill_inc == cap_r) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            head_r       <= head_nxt;
            used_r       <= used_nxt;
            out_valid_r  <= 1'b1;
            out_status_r <= res_status;
            out_slot_r   <= res_slot;
            out_boff_r   <= res_boff;
            out_unused_r <= res_unused;
            out_full_r   <= (used_nxt == cap_r);
            out_empty_r  <= (used_nxt == '0);
            out_used_r   <= used_nxt;
            out_cap_r    <= cap_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.slot_out         = out_slot_r;
  assign out_ch.slot_byte_offset = out_boff_r;
  assign out_ch.page_now_unused  = out_unused_r;
  assign out_ch.is_full          = out_full_r;
  assign out_ch.is_empty         = out_empty_r;
  assign out_ch.used_slots       = out_used_r;
  assign out_ch.capacity_out     = out_cap_r;

endmodule
